// File: hw/rtl/spo2_pkg.sv
// ----------------------------------------------------------------------------
// spo2_pkg
// Shared types for the ratio-of-ratios SpO2 block.
// ----------------------------------------------------------------------------
package spo2_pkg;

  localparam int SAMPLE_BITS = 18;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] red_sample;
    logic [SAMPLE_BITS-1:0] ir_sample;
    logic                   clear;
  } in_item_t;

  typedef struct packed {
    logic [6:0]  spo2_percent;
    logic [15:0] ratio_q8;
    logic        window_ready;
    logic        reading_valid;
  } out_item_t;

  // lane request from top to the per-channel statistics lanes
  typedef struct packed {
    logic start;
    logic clear;
  } lane_ctl_t;

  localparam int unsigned RATIO_MAX = 65535;
  localparam int unsigned SPO2_OFFSET = 110;

endpackage

// File: hw/rtl/spo2_lane.sv
// ----------------------------------------------------------------------------
// spo2_lane
// One channel window: ring memory, running sum and sum of squares, and the
// scaled variance V = N*Q - S*S, computed in the ph_r phases after a sample request.
// ----------------------------------------------------------------------------
module spo2_lane #(
  parameter int DEPTH       = 64,
  parameter int SAMPLE_BITS = 18
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  spo2_pkg::lane_ctl_t   ctl,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [$clog2(DEPTH)-1:0] slot,
  input  logic                  init_we,
  input  logic [$clog2(DEPTH)-1:0] init_addr,
  output logic [SAMPLE_BITS+$clog2(DEPTH+1)-1:0] sum_q,
  output logic [2*(SAMPLE_BITS+$clog2(DEPTH+1))-1:0] var_q,
  output logic                  done
);
  localparam int SW  = SAMPLE_BITS + $clog2(DEPTH + 1);
  localparam int QW  = 2 * SAMPLE_BITS + $clog2(DEPTH + 1);
  localparam int VW  = 2 * SW;
  localparam int PSW = 2 * SAMPLE_BITS;

  logic [SAMPLE_BITS-1:0] mem [DEPTH];
  logic [SAMPLE_BITS-1:0] old_r;
  logic [SW-1:0] sum_r;
  logic [QW-1:0] sq_r;
  logic [PSW-1:0] old_sq_r, new_sq_r;
  logic [VW-1:0] ss_r, var_r;
  logic [4:0] ph_r;

  // memory: clearing pass writes zero, otherwise a sample request writes the sample
  always_ff @(posedge clk) begin
    if (init_we) begin
      mem[init_addr] <= '0;
    end else if (ctl.start && !ctl.clear) begin
      mem[slot] <= sample;
    end
    old_r <= mem[slot];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r  <= '0;
      sum_r <= '0;
      sq_r  <= '0;
    end else begin
      ph_r <= {ph_r[3:0], ctl.start && !ctl.clear};
      if (ctl.start && ctl.clear) begin
        sum_r <= '0;
        sq_r  <= '0;
      end
      if (ph_r[0]) begin
        old_sq_r <= PSW'(old_r) * PSW'(old_r);
        new_sq_r <= PSW'(sample) * PSW'(sample);
        sum_r <= sum_r - SW'(old_r) + SW'(sample);
      end
      if (ph_r[1]) begin
        sq_r <= sq_r - QW'(old_sq_r) + QW'(new_sq_r);
      end
      if (ph_r[2]) begin
        ss_r <= VW'(sum_r) * VW'(sum_r);
      end
      if (ph_r[3]) begin
        var_r <= VW'(DEPTH) * VW'(sq_r) - ss_r;
      end
    end
  end

  assign sum_q = sum_r;
  assign var_q = var_r;
  // var_r is loaded at the ph_r[3] edge
  assign done  = ph_r[4];
endmodule

// File: hw/rtl/spo2_merge.sv
// ----------------------------------------------------------------------------
// spo2_merge
// Combines both lanes: forms num = Vr*Si^2 and den = Vi*Sr^2 with a serial
// multiplier, then finds ratio_q8 and the SpO2 step by bitwise search.
// ----------------------------------------------------------------------------
module spo2_merge #(
  parameter int SW = 25,
  parameter int VW = 50
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [SW-1:0] red_sum,
  input  logic [SW-1:0] ir_sum,
  input  logic [VW-1:0] red_var,
  input  logic [VW-1:0] ir_var,
  output logic [15:0]   ratio,
  output logic [6:0]    spo2,
  output logic          done
);
  localparam int PW = VW + 2 * SW;      // num / den width
  localparam int CW = PW + 32;          // compare width
  localparam int MW = $clog2(PW + 1);
  localparam int BW = 2 * SW;
  localparam logic [7:0] SPO2_OFF = 8'(spo2_pkg::SPO2_OFFSET);

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_PREP, S_RATIO, S_KSRCH, S_DONE} st_t;
  st_t st_r;

  logic [PW-1:0] acc_n_r, acc_d_r;
  logic [PW-1:0] mn_r, md_r;
  logic [BW-1:0] bn_r, bd_r;
  logic [MW-1:0] cnt_r;
  logic [15:0] ratio_r;
  logic [4:0] bit_r;
  logic [6:0] k_r;
  // search terms for trial t = x | 2^b: den*x^2, den*x*2^(b+1), den*2^(2b)
  logic [CW-1:0] goal_r, sq_r, cross_r, step_r;
  logic [CW-1:0] cand, goal_k;
  logic take;

  assign cand   = sq_r + cross_r + step_r;
  // num * 625
  assign goal_k = (CW'(acc_n_r) << 9) + (CW'(acc_n_r) << 6) + (CW'(acc_n_r) << 5)
                  + (CW'(acc_n_r) << 4) + CW'(acc_n_r);
  assign take   = (st_r == S_RATIO) ? (cand <= goal_r) : (cand < goal_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      done  <= 1'b0;
      ratio <= '0;
      spo2  <= '0;
    end else begin
      done <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (start) begin
            mn_r    <= PW'(red_var);
            md_r    <= PW'(ir_var);
            bn_r    <= BW'(ir_sum) * BW'(ir_sum);
            bd_r    <= BW'(red_sum) * BW'(red_sum);
            acc_n_r <= '0;
            acc_d_r <= '0;
            cnt_r   <= '0;
            st_r    <= S_MUL;
          end
        end
        S_MUL: begin
          // shift-add product, one multiplier bit per cycle per operand
          if (bn_r[0]) acc_n_r <= acc_n_r + mn_r;
          if (bd_r[0]) acc_d_r <= acc_d_r + md_r;
          mn_r  <= mn_r << 1;
          md_r  <= md_r << 1;
          bn_r  <= bn_r >> 1;
          bd_r  <= bd_r >> 1;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == MW'(2*SW - 1)) st_r <= S_PREP;
        end
        S_PREP: begin
          // den*t^2 <= num*65536
          goal_r  <= CW'(acc_n_r) << 16;
          sq_r    <= '0;
          cross_r <= '0;
          step_r  <= CW'(acc_d_r) << 30;
          ratio_r <= '0;
          bit_r   <= 5'd15;
          st_r    <= S_RATIO;
        end
        S_RATIO, S_KSRCH: begin
          // ratio: largest t with den*t^2 <= num*65536
          // k: largest k with den*k^2 < num*625; ceil(25*ratio) is that plus one
          if (take) begin
            if (st_r == S_RATIO) ratio_r <= ratio_r | (16'd1 << bit_r[3:0]);
            else k_r <= k_r | (7'd1 << bit_r[2:0]);
          end
          if (bit_r == 5'd0) begin
            if (st_r == S_RATIO) begin
              goal_r  <= goal_k;
              sq_r    <= '0;
              cross_r <= '0;
              step_r  <= CW'(acc_d_r) << 12;
              k_r     <= '0;
              bit_r   <= 5'd6;
              st_r    <= S_KSRCH;
            end else begin
              st_r <= S_DONE;
            end
          end else begin
            if (take) begin
              sq_r    <= cand;
              cross_r <= (cross_r >> 1) + step_r;
            end else begin
              cross_r <= cross_r >> 1;
            end
            step_r <= step_r >> 2;
            bit_r  <= bit_r - 1'b1;
          end
        end
        S_DONE: begin
          ratio <= ratio_r;
          if (k_r >= 7'd109)     spo2 <= '0;
          else if (k_r <= 7'd9)  spo2 <= 7'd100;
          else                   spo2 <= 7'(SPO2_OFF - 8'(k_r) - 8'd1);
          done <= 1'b1;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

// File: hw/rtl/spo2_ratio_of_ratios.sv
// ----------------------------------------------------------------------------
// spo2_ratio_of_ratios
// Ratio-of-ratios pulse oximetry: windowed red/IR statistics and SpO2.
// ----------------------------------------------------------------------------
// One request at a time. A sample request with a full window and a valid
// reading passes through the lane statistics, the serial shift-add multiplier
// forming the cross products, then a 16-step search for the ratio and a 7-step
// search for the SpO2 step in the merge unit. Any other sample request returns
// once the lane statistics are done, a clear request the cycle after acceptance.
// After a sample request, a new request is taken the cycle after its result is
// accepted. After reset and after every clear a pass over every slot zeroes
// both window memories before the next request is taken.
module spo2_ratio_of_ratios #(
  parameter int DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  spo2_pkg::in_item_t    in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output spo2_pkg::out_item_t   out_data
);
  localparam int SAMPLE_BITS = spo2_pkg::SAMPLE_BITS;
  localparam int AW = $clog2(DEPTH);
  localparam int SW = SAMPLE_BITS + $clog2(DEPTH + 1);
  localparam int VW = 2 * SW;

  typedef enum logic [2:0] {T_INIT, T_IDLE, T_LANE, T_MERGE, T_OUT} st_t;
  st_t st_r;

  logic [AW-1:0] slot_r, init_r;
  logic filled_r;
  logic [SAMPLE_BITS-1:0] red_hold_r, ir_hold_r;
  logic [SAMPLE_BITS-1:0] red_smp, ir_smp;
  spo2_pkg::lane_ctl_t ctl;
  logic [SW-1:0] rsum, isum;
  logic [VW-1:0] rvar, ivar;
  logic rdone, idone, lanes_done, mdone, mstart;
  logic [15:0] m_ratio;
  logic [6:0] m_spo2;

  assign in_ready = (st_r == T_IDLE) && !out_valid;
  assign ctl.start = in_valid && in_ready;
  assign ctl.clear = in_data.clear;

  spo2_lane #(.DEPTH(DEPTH), .SAMPLE_BITS(SAMPLE_BITS)) u_red (
    .clk, .rst_n, .ctl, .sample(red_smp), .slot(slot_r),
    .init_we(st_r == T_INIT), .init_addr(init_r),
    .sum_q(rsum), .var_q(rvar), .done(rdone));
  spo2_lane #(.DEPTH(DEPTH), .SAMPLE_BITS(SAMPLE_BITS)) u_ir (
    .clk, .rst_n, .ctl, .sample(ir_smp), .slot(slot_r),
    .init_we(st_r == T_INIT), .init_addr(init_r),
    .sum_q(isum), .var_q(ivar), .done(idone));

  assign red_smp = in_ready ? in_data.red_sample : red_hold_r;
  assign ir_smp  = in_ready ? in_data.ir_sample  : ir_hold_r;

  assign lanes_done = rdone && idone;
  assign mstart = lanes_done && filled_r && rsum != '0 && isum != '0
                  && rvar != '0 && ivar != '0;

  spo2_merge #(.SW(SW), .VW(VW)) u_merge (
    .clk, .rst_n, .start(mstart), .red_sum(rsum), .ir_sum(isum),
    .red_var(rvar), .ir_var(ivar), .ratio(m_ratio), .spo2(m_spo2),
    .done(mdone));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= T_INIT;
      init_r    <= '0;
      slot_r    <= '0;
      filled_r  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (st_r)
        T_INIT: begin
          init_r <= init_r + 1'b1;
          if (init_r == AW'(DEPTH - 1)) st_r <= T_IDLE;
        end
        T_IDLE: begin
          if (ctl.start) begin
            red_hold_r <= in_data.red_sample;
            ir_hold_r  <= in_data.ir_sample;
            if (in_data.clear) begin
              // restart the window: zero memories again
              slot_r   <= '0;
              filled_r <= 1'b0;
              init_r   <= '0;
              out_data <= '0;
              out_valid <= 1'b1;
              st_r     <= T_INIT;
            end else begin
              if (slot_r == AW'(DEPTH - 1)) begin
                slot_r   <= '0;
                filled_r <= 1'b1;
              end else begin
                slot_r <= slot_r + 1'b1;
              end
              st_r <= T_LANE;
            end
          end
        end
        T_LANE: begin
          if (lanes_done) begin
            out_data <= '{spo2_percent: '0, ratio_q8: '0,
                          window_ready: filled_r, reading_valid: 1'b0};
            if (mstart) st_r <= T_MERGE;
            else begin
              out_valid <= 1'b1;
              st_r <= T_IDLE;
            end
          end
        end
        T_MERGE: begin
          if (mdone) begin
            out_data <= '{spo2_percent: m_spo2, ratio_q8: m_ratio,
                          window_ready: filled_r, reading_valid: 1'b1};
            out_valid <= 1'b1;
            st_r <= T_IDLE;
          end
        end
        default: st_r <= T_IDLE;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != T_IDLE) |-> !in_ready) else $error("accept while busy");
  a_valid_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.spo2_percent <= 7'd100) else $error("spo2 range");
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.window_ready) |-> !out_data.reading_valid)
    else $error("valid reading before window filled");
endmodule

// File: verif/spo2_ratio_of_ratios_test.sv
// ----------------------------------------------------------------------------
// spo2_ratio_of_ratios_test
// Self-checking bench for the ratio-of-ratios SpO2 block: a directed table
// with listed results, then random waveform segments predicted by an exact
// wide-integer model of the window statistics, all checked in order.
// ----------------------------------------------------------------------------
module spo2_ratio_of_ratios_test;

  localparam int          WIN       = 64;
  localparam int          N_RANDOM  = 900;
  localparam int unsigned SAMPLE_MAX = 262143;
  localparam longint      CYCLE_LIMIT = 2000000;

  // waveform shapes for the random segments
  typedef enum int {
    SHAPE_PULSE, SHAPE_FLAT_RED, SHAPE_FLAT_IR, SHAPE_ZERO_RED, SHAPE_NOISE,
    SHAPE_SATURATE, SHAPE_TINY, SHAPE_RAILS
  } shape_t;

  typedef struct {
    spo2_pkg::in_item_t  req;
    bit                  known;
    spo2_pkg::out_item_t res;
  } table_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  spo2_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  spo2_pkg::out_item_t out_data;

  spo2_pkg::out_item_t pending_results[$];
  table_row_t  table_rows[$];
  int          n_errors = 0;
  int          n_checked = 0;
  longint      cycle_count = 0;

  // predictor state
  logic [17:0] red_win[WIN];
  logic [17:0] ir_win[WIN];
  int          win_slot;
  bit          win_full;
  logic [63:0] red_s, ir_s, red_q, ir_q;

  spo2_ratio_of_ratios i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t timeout", $time);
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic void clear_windows();
    for (int i = 0; i < WIN; i++) begin
      red_win[i] = '0;
      ir_win[i]  = '0;
    end
    win_slot = 0;
    win_full = 1'b0;
    red_s = '0;
    ir_s  = '0;
    red_q = '0;
    ir_q  = '0;
  endfunction

  function automatic spo2_pkg::out_item_t predict_spo2(spo2_pkg::in_item_t req);
    spo2_pkg::out_item_t res;
    logic [63:0] r, s, old_r, old_s, var_r, var_i, lo, hi, mid, k;
    logic [191:0] num, den, goal, lhs;
    res = '0;
    if (req.clear) begin
      clear_windows();
    end else begin
      r = 64'(req.red_sample);
      s = 64'(req.ir_sample);
      old_r = 64'(red_win[win_slot]);
      old_s = 64'(ir_win[win_slot]);
      red_s = red_s - old_r + r;
      ir_s  = ir_s - old_s + s;
      red_q = red_q - old_r * old_r + r * r;
      ir_q  = ir_q - old_s * old_s + s * s;
      red_win[win_slot] = req.red_sample;
      ir_win[win_slot]  = req.ir_sample;
      win_slot = (win_slot + 1) % WIN;
      if (win_slot == 0) win_full = 1'b1;
    end
    res.window_ready = win_full;
    if (win_full && red_s != 0 && ir_s != 0) begin
      var_r = 64'(WIN) * red_q - red_s * red_s;
      var_i = 64'(WIN) * ir_q - ir_s * ir_s;
      if (var_r != 0 && var_i != 0) begin
        num = 192'(var_r) * 192'(ir_s) * 192'(ir_s);
        den = 192'(var_i) * 192'(red_s) * 192'(red_s);
        goal = num * 192'(65536);
        lo = 0;
        hi = spo2_pkg::RATIO_MAX;
        while (lo < hi) begin
          mid = (lo + hi + 1) >> 1;
          lhs = den * 192'(mid * mid);
          if (lhs <= goal) lo = mid;
          else hi = mid - 1;
        end
        res.ratio_q8 = lo[15:0];
        // smallest k with k >= 25*ratio
        goal = num * 192'(625);
        for (k = 0; k < 112; k++) begin
          lhs = den * 192'(k * k);
          if (lhs >= goal) break;
        end
        if (k >= spo2_pkg::SPO2_OFFSET) res.spo2_percent = '0;
        else if (k <= 10) res.spo2_percent = 7'd100;
        else res.spo2_percent = 7'(spo2_pkg::SPO2_OFFSET - k);
        res.reading_valid = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [17:0] draw(int unsigned base, int unsigned amp);
    int unsigned v;
    v = base + $urandom_range(0, amp);
    return (v > SAMPLE_MAX) ? 18'(SAMPLE_MAX) : 18'(v);
  endfunction

  function automatic void add_row(int unsigned red, int unsigned ir, bit clr);
    table_row_t row;
    row.req.red_sample = 18'(red);
    row.req.ir_sample  = 18'(ir);
    row.req.clear      = clr;
    row.known = 1'b1;
    row.res   = '0;  // window never fills within the table
    table_rows.push_back(row);
  endfunction

  task automatic send_request(spo2_pkg::in_item_t req, bit known,
                              spo2_pkg::out_item_t typed);
    spo2_pkg::out_item_t predicted;
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    predicted = predict_spo2(req);
    pending_results.push_back(known ? typed : predicted);
  endtask

  // sender
  initial begin
    spo2_pkg::in_item_t req;
    shape_t      shape;
    int unsigned rb, ra, ib, ia, seg_len;
    int          sent;
    clear_windows();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    add_row(0, 0, 1'b1);
    add_row(SAMPLE_MAX, SAMPLE_MAX, 1'b0);
    add_row(0, 0, 1'b0);
    add_row(SAMPLE_MAX, 0, 1'b0);
    add_row(0, SAMPLE_MAX, 1'b0);
    add_row(18'h2aaaa, 18'h15555, 1'b0);
    add_row(18'h15555, 18'h2aaaa, 1'b0);
    add_row(SAMPLE_MAX, SAMPLE_MAX, 1'b1);
    for (int i = 0; i < 12; i++)
      add_row(1000 + 37 * i, 2000 - 29 * i, 1'b0);
    add_row(1, 1, 1'b1);
    foreach (table_rows[i])
      send_request(table_rows[i].req, table_rows[i].known, table_rows[i].res);

    sent = 0;
    while (sent < N_RANDOM) begin
      shape = shape_t'($urandom_range(0, 11) > 7 ? SHAPE_PULSE : $urandom_range(0, 7));
      rb = $urandom_range(1000, 200000);
      ra = $urandom_range(1, rb / 4);
      ib = $urandom_range(1000, 200000);
      ia = $urandom_range(1, ib / 4);
      case (shape)
        SHAPE_FLAT_RED: ra = 0;
        SHAPE_FLAT_IR:  ia = 0;
        SHAPE_ZERO_RED: begin rb = 0; ra = 0; end
        SHAPE_NOISE: begin
          rb = 0; ra = SAMPLE_MAX; ib = 0; ia = SAMPLE_MAX;
        end
        SHAPE_SATURATE: begin
          rb = $urandom_range(1, 50); ra = $urandom_range(50, 4000);
          ib = 200000; ia = 1;
        end
        SHAPE_TINY: begin
          rb = 200000; ra = 1; ib = 10; ia = 10000;
        end
        default: ;
      endcase
      seg_len = $urandom_range(60, 150);
      for (int j = 0; j < seg_len && sent < N_RANDOM; j++) begin
        if (shape == SHAPE_RAILS) begin
          req.red_sample = $urandom_range(0, 1) ? 18'(SAMPLE_MAX) : 18'd0;
          req.ir_sample  = $urandom_range(0, 1) ? 18'(SAMPLE_MAX) : 18'd0;
        end else begin
          req.red_sample = draw(rb, ra);
          req.ir_sample  = draw(ib, ia);
        end
        req.clear = ($urandom_range(0, 199) == 0);
        send_request(req, 1'b0, '0);
        sent++;
        if (sent == N_RANDOM / 2) begin
          in_valid <= 1'b0;
          wait (pending_results.size() == 0);
          @(posedge clk);
        end
      end
    end
    in_valid <= 1'b0;

    wait (pending_results.size() == 0);
    repeat (200) @(posedge clk);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // result checker and receiver stalls
  initial begin
    spo2_pkg::out_item_t want;
    int        stall_left;
    bit        long_hold_done;
    stall_left = 0;
    long_hold_done = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t unexpected result %p", $time, out_data);
          n_errors++;
        end else begin
          want = pending_results.pop_front();
          if (out_data.spo2_percent !== want.spo2_percent) begin
            $display("%0t spo2_percent expected %0d actual %0d", $time,
                     want.spo2_percent, out_data.spo2_percent);
            n_errors++;
          end
          if (out_data.ratio_q8 !== want.ratio_q8) begin
            $display("%0t ratio_q8 expected %0d actual %0d", $time,
                     want.ratio_q8, out_data.ratio_q8);
            n_errors++;
          end
          if (out_data.window_ready !== want.window_ready) begin
            $display("%0t window_ready expected %0b actual %0b", $time,
                     want.window_ready, out_data.window_ready);
            n_errors++;
          end
          if (out_data.reading_valid !== want.reading_valid) begin
            $display("%0t reading_valid expected %0b actual %0b", $time,
                     want.reading_valid, out_data.reading_valid);
            n_errors++;
          end
          n_checked++;
        end
      end
      // one long hold-off while the sender keeps offering
      if (!long_hold_done && n_checked >= 300) begin
        long_hold_done = 1'b1;
        stall_left = 400;
      end else if (stall_left == 0) begin
        stall_left = idle_len();
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

endmodule
